FILE: hw/rtl/salc_pkg.sv
// shared types, constants and helpers of the set-associative lru tag cache
package salc_pkg;

    // geometry
    localparam int MAX_SETS  = 1024;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 32;

    localparam int SET_BITS  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_BITS  = WAY_BITS;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W   = $clog2(SET_BITS + 1);
    localparam int TAG_BITS  = ADDR_BITS;
    localparam int CNT_BITS  = 32;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] REG_BLOCK_SHIFT = 2'd0;
    localparam logic [1:0] REG_SET_SHIFT   = 2'd1;
    localparam logic [1:0] REG_WAY_COUNT   = 2'd2;

    localparam logic [CFG_W-1:0] BLOCK_SHIFT_RST = 4'd6;
    localparam logic [CFG_W-1:0] SET_SHIFT_RST   = 4'd6;
    localparam logic [CFG_W-1:0] WAY_COUNT_RST   = 4'd4;

    // result fields
    localparam int SET_OUT_W  = 10;
    localparam int WAY_OUT_W  = 3;
    localparam int OUT_BITS   = SET_OUT_W + WAY_OUT_W + 5 * CNT_BITS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // register values as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] block_shift;
        logic [CFG_W-1:0] set_shift;
        logic [CFG_W-1:0] way_count;
    } salc_cfg_t;

    // one memory row holds a whole set
    typedef struct packed {
        logic [CNT_BITS-1:0]                miss_cnt;
        logic [MAX_WAYS-1:0][AGE_BITS-1:0]  age;
        logic [MAX_WAYS-1:0][TAG_BITS-1:0]  tag;
    } salc_row_t;

    localparam int ROW_W = $bits(salc_row_t);

    // outcome of one lookup
    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way_used;
    } salc_lookup_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } salc_state_t;

    // row contents after reset: zero tags, ages equal to the way number
    function automatic salc_row_t salc_reset_row();
        salc_row_t r;
        r = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            r.age[w] = AGE_BITS'(w);
        end
        return r;
    endfunction

    // counter that stops at all ones
    function automatic logic [CNT_BITS-1:0] salc_sat_inc(input logic [CNT_BITS-1:0] v);
        return (&v) ? v : v + CNT_BITS'(1);
    endfunction

endpackage

FILE: hw/rtl/salc_row_ram.sv
// simple dual-port ram with one registered read port
module salc_row_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered on re
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/salc_cfg_regs.sv
// apb configuration registers: block shift, set shift, way count
module salc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [salc_pkg::PADDR_W-1:0]   paddr,
    input  logic [salc_pkg::PDATA_W-1:0]   pwdata,
    output logic [salc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output salc_pkg::salc_cfg_t            cfg
);
    import salc_pkg::*;

    logic [CFG_W-1:0] block_shift_reg;
    logic [CFG_W-1:0] set_shift_reg;
    logic [CFG_W-1:0] way_count_reg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_shift_reg <= BLOCK_SHIFT_RST;
            set_shift_reg   <= SET_SHIFT_RST;
            way_count_reg   <= WAY_COUNT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BLOCK_SHIFT: block_shift_reg <= pwdata[CFG_W-1:0];
                REG_SET_SHIFT:   set_shift_reg   <= pwdata[CFG_W-1:0];
                REG_WAY_COUNT:   way_count_reg   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_BLOCK_SHIFT: prdata = PDATA_W'(block_shift_reg);
            REG_SET_SHIFT:   prdata = PDATA_W'(set_shift_reg);
            REG_WAY_COUNT:   prdata = PDATA_W'(way_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.block_shift = block_shift_reg;
    assign cfg.set_shift   = set_shift_reg;
    assign cfg.way_count   = way_count_reg;

endmodule

FILE: hw/rtl/salc_way_logic.sv
// tag compare over all ways of a set, lru aging and set miss count update
module salc_way_logic (
    input  salc_pkg::salc_row_t               row_in,
    input  logic [salc_pkg::TAG_BITS-1:0]     tag,
    input  logic [salc_pkg::WAY_CNT_W-1:0]    ways,
    output salc_pkg::salc_row_t               row_out,
    output salc_pkg::salc_lookup_t            result
);
    import salc_pkg::*;

    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [AGE_BITS-1:0] max_age;
    logic [AGE_BITS-1:0] pivot;
    logic                found;
    logic [WAY_BITS-1:0] used;

    // first matching way, and oldest age for the miss case
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        max_age = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(ways)) begin
                if (!hit && row_in.tag[w] == tag) begin
                    hit     = 1'b1;
                    hit_way = WAY_BITS'(w);
                end
                if (row_in.age[w] > max_age) begin
                    max_age = row_in.age[w];
                end
            end
        end
        pivot = hit ? row_in.age[hit_way] : max_age;
    end

    // age younger ways, rewrite ways at the pivot age
    always_comb begin
        row_out = row_in;
        found   = 1'b0;
        used    = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(ways)) begin
                if (row_in.age[w] < pivot) begin
                    row_out.age[w] = row_in.age[w] + AGE_BITS'(1);
                end else if (row_in.age[w] == pivot) begin
                    row_out.tag[w] = tag;
                    row_out.age[w] = '0;
                    if (!found) begin
                        used  = WAY_BITS'(w);
                        found = 1'b1;
                    end
                end
            end
        end
        row_out.miss_cnt = hit ? row_in.miss_cnt : salc_sat_inc(row_in.miss_cnt);
    end

    assign result.hit      = hit;
    assign result.way_used = used;

endmodule

FILE: hw/rtl/set_associative_lru_cache_tags.sv
// Tag-only set-associative cache with true LRU replacement and hit/miss counters.
// Each access reads the set row (tags, ages and the set's miss count for all ways)
// from a single row memory in the cycle the beat is accepted, then compares, ages
// and writes it back in the lookup state while the result beat is loaded into the
// output register. The lookup waits until the output register is drained; the
// input takes no new beat until the last lookup is done, so a stalled result
// holds the lookup and the input. After reset a clearing pass writes the reset
// row into all 1024 sets, one set a cycle, so the input stays not ready until
// the pass ends; configuration writes are taken during that time.
module set_associative_lru_cache_tags (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beat
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [salc_pkg::ADDR_BITS-1:0]    s_tdata,   // [31:0] address
    input  logic                              s_tuser,   // [0] is_write
    // result beat
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] set_index, [12:10] way_used, [44:13] set_misses, [76:45] read_hits,
    // [108:77] read_misses, [140:109] write_hits, [172:141] write_misses, rest zero
    output logic [salc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,   // [0] miss
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::PADDR_W-1:0]      paddr,
    input  logic [salc_pkg::PDATA_W-1:0]      pwdata,
    output logic [salc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import salc_pkg::*;

    salc_cfg_t           cfg;
    salc_state_t         state_reg, state_next;
    logic [SET_BITS-1:0] clr_idx_reg;

    logic                acc;
    logic [ADDR_BITS-1:0] blk;
    logic [SHIFT_W-1:0]  ss_eff;
    logic [SET_BITS-1:0] set_calc;
    logic [TAG_BITS-1:0] tag_calc;
    logic [WAY_CNT_W-1:0] ways_eff;

    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                wr_reg;

    logic                ram_we;
    logic [SET_BITS-1:0] ram_waddr;
    salc_row_t           ram_wdata;
    salc_row_t           row_rd;
    salc_row_t           row_new;
    salc_lookup_t        lk;
    logic                out_free;
    logic                ld_out;

    logic [CNT_BITS-1:0] rd_hit_reg, rd_miss_reg, wr_hit_reg, wr_miss_reg;
    logic [CNT_BITS-1:0] rd_hit_next, rd_miss_next, wr_hit_next, wr_miss_next;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    // configuration registers
    salc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // address split: saturate set shift, then set index and tag
    always_comb begin
        ss_eff   = (int'(cfg.set_shift) > SET_BITS) ? SHIFT_W'(SET_BITS)
                                                    : SHIFT_W'(cfg.set_shift);
        blk      = s_tdata >> cfg.block_shift;
        set_calc = blk[SET_BITS-1:0] & ~({SET_BITS{1'b1}} << ss_eff);
        tag_calc = blk >> ss_eff;
    end

    // ways in use, clamped to one..MAX_WAYS
    always_comb begin
        if (cfg.way_count == '0) begin
            ways_eff = WAY_CNT_W'(1);
        end else if (int'(cfg.way_count) > MAX_WAYS) begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WAY_CNT_W'(cfg.way_count);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ld_out   = (state_reg == ST_LOOKUP) && out_free;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (&clr_idx_reg) state_next = ST_IDLE;
            ST_IDLE:   if (acc) state_next = ST_LOOKUP;
            ST_LOOKUP: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // clearing pass index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_idx_reg <= clr_idx_reg + SET_BITS'(1);
        end
    end

    // captured access
    always_ff @(posedge aclk) begin
        if (acc) begin
            set_reg <= set_calc;
            tag_reg <= tag_calc;
            wr_reg  <= s_tuser;
        end
    end

    // row memory write: reset rows while clearing, updated row on lookup
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = row_new;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = salc_reset_row();
        end else if (ld_out) begin
            ram_we = 1'b1;
        end
    end

    salc_row_ram #(
        .DATA_W (ROW_W),
        .ADDR_W (SET_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc),
        .raddr (set_calc),
        .rdata (row_rd)
    );

    salc_way_logic u_way (
        .row_in  (row_rd),
        .tag     (tag_reg),
        .ways    (ways_eff),
        .row_out (row_new),
        .result  (lk)
    );

    // global hit and miss totals
    always_comb begin
        rd_hit_next  = rd_hit_reg;
        rd_miss_next = rd_miss_reg;
        wr_hit_next  = wr_hit_reg;
        wr_miss_next = wr_miss_reg;
        if (wr_reg) begin
            if (lk.hit) wr_hit_next  = salc_sat_inc(wr_hit_reg);
            else        wr_miss_next = salc_sat_inc(wr_miss_reg);
        end else begin
            if (lk.hit) rd_hit_next  = salc_sat_inc(rd_hit_reg);
            else        rd_miss_next = salc_sat_inc(rd_miss_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg  <= '0;
            rd_miss_reg <= '0;
            wr_hit_reg  <= '0;
            wr_miss_reg <= '0;
        end else if (ld_out) begin
            rd_hit_reg  <= rd_hit_next;
            rd_miss_reg <= rd_miss_next;
            wr_hit_reg  <= wr_hit_next;
            wr_miss_reg <= wr_miss_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ld_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_tuser_reg <= !lk.hit;
            m_tdata_reg <= OUT_DATA_W'({wr_miss_next, wr_hit_next, rd_miss_next,
                                        rd_hit_next, row_new.miss_cnt,
                                        WAY_OUT_W'(lk.way_used),
                                        SET_OUT_W'(set_reg)});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted beat always goes to lookup
    a_acc_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> state_reg == ST_LOOKUP)
        else $error("accepted beat did not start a lookup");

    // no access is taken while the clearing pass runs
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input ready during clearing pass");

    // the row memory is never written while idle
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg != ST_IDLE)
        else $error("row write while idle");

    // a miss result carries a nonzero set miss count
    a_miss_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_out && !lk.hit) |=> (m_tvalid && m_tuser && m_tdata[44:13] != '0))
        else $error("miss result with zero set miss count");

    // the reported way lies inside the ways in use
    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_out |-> WAY_CNT_W'(lk.way_used) < ways_eff)
        else $error("reported way outside the ways in use");

endmodule
